FILE: hw/rtl/interrupt_controller_registers_core_defines.svh
// Assertion macros used by the checker file of the interrupt controller.
// No dependencies; include by bare file name.
`ifndef INTERRUPT_CONTROLLER_REGISTERS_CORE_DEFINES_SVH
`define INTERRUPT_CONTROLLER_REGISTERS_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define ICR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ICR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/icr_pkg.sv
// Package of the interrupt controller register core: command and config
// index codes, register offsets and reset values. No dependencies.
package icr_pkg;

    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LINE_W  = 5;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LINE  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAN     = 2'd0,
        CFG_PRINTER = 2'd1,
        CFG_SERIAL  = 2'd2
    } cfg_idx_t;

    localparam logic [ADDR_W-1:0] OFF_REQUEST = 20'h00000;
    localparam logic [ADDR_W-1:0] OFF_MASK    = 20'h00004;
    localparam logic [ADDR_W-1:0] OFF_PENDING = 20'h00008;
    localparam logic [ADDR_W-1:0] OFF_CONTROL = 20'h0000C;
    localparam logic [ADDR_W-1:0] OFF_TARGET  = 20'h00010;
    localparam logic [ADDR_W-1:0] OFF_POWER   = 20'h0C000;
    localparam logic [ADDR_W-1:0] OFF_VERSION = 20'h0C008;
    localparam logic [ADDR_W-1:0] OFF_IORESET = 20'h0C00C;

    localparam logic [ADDR_W-1:0] LAN_RESET     = 20'h07000;
    localparam logic [ADDR_W-1:0] PRINTER_RESET = 20'h02000;
    localparam logic [ADDR_W-1:0] SERIAL_RESET  = 20'h05000;

    localparam int unsigned       DISABLE_BIT   = 7;
    localparam logic [DATA_W-1:0] POWER_OFF_VAL = 32'h0000_0002;
    localparam logic [DATA_W-1:0] TARGET_RESET  = 32'hFFFB_0003;

endpackage

FILE: hw/rtl/interrupt_controller_registers_core.sv
// Interrupt controller register core: one input channel (s_) carries bus
// reads, bus writes and interrupt line events; one result channel (m_)
// returns one result word per input word. A config channel (cfg_) sets the
// three sub-device slot offsets.
//
// Usage:
//   - Each accepted input word updates the request, mask, pending, control
//     and target registers and produces its result in the result register.
//     Throughput is 1 word per cycle while the receiver does not stall.
//   - The rate is set by the single result register: a new word is taken
//     whenever the result register is empty or is being drained that cycle.
//   - When the receiver stalls (m_ready low with m_valid high), the result
//     holds and s_ready drops until the result is taken.
//   - cfg_ready is always high; a write lands at the next edge. Index 3 is
//     accepted and ignored.
//   - Reset (aresetn low, synchronous) clears all interrupt state, sets the
//     target to its default and the slot offsets to their defaults, and
//     empties the result register.
// Depends on icr_pkg.
module interrupt_controller_registers_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [icr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [icr_pkg::ADDR_W-1:0]    cfg_wdata,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [icr_pkg::ADDR_W-1:0]    s_address,
    input  logic [icr_pkg::DATA_W-1:0]    s_write_data,
    input  logic [icr_pkg::LINE_W-1:0]    s_irq_line,
    input  logic                          s_irq_level,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [icr_pkg::DATA_W-1:0]    m_read_data,
    output logic                          m_access_status,
    output logic                          m_notify_valid,
    output logic [icr_pkg::DATA_W-1:0]    m_notify_address,
    output logic [icr_pkg::LINE_W-1:0]    m_notify_value,
    output logic                          m_power_off
);
    import icr_pkg::*;

    logic [ADDR_W-1:0] lan_reg, printer_reg, serial_reg;
    logic [DATA_W-1:0] request_reg, request_next;
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic [DATA_W-1:0] pending_reg, pending_next;
    logic              disable_reg, disable_next;
    logic [DATA_W-1:0] target_reg, target_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              status_reg, status_next;
    logic              nvalid_reg, nvalid_next;
    logic [DATA_W-1:0] naddr_reg, naddr_next;
    logic [LINE_W-1:0] nval_reg, nval_next;
    logic              poff_reg, poff_next;

    logic              accept;
    logic              is_dummy;
    logic [DATA_W-1:0] line_bit;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign is_dummy = (s_address == lan_reg) || (s_address == printer_reg) ||
                      (s_address == serial_reg) || (s_address == OFF_POWER) ||
                      (s_address == OFF_VERSION) || (s_address == OFF_IORESET);
    assign line_bit = {{(DATA_W-1){1'b0}}, 1'b1} << s_irq_line;

    always_comb begin
        request_next = request_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        disable_next = disable_reg;
        target_next  = target_reg;
        rd_next      = '0;
        status_next  = 1'b0;
        nvalid_next  = 1'b0;
        naddr_next   = '0;
        nval_next    = '0;
        poff_next    = 1'b0;
        case (cmd_t'(s_cmd))
            CMD_READ: begin
                if (s_address == OFF_REQUEST) begin
                    rd_next = request_reg;
                end else if (s_address == OFF_MASK) begin
                    rd_next = mask_reg;
                end else if (s_address == OFF_PENDING) begin
                    rd_next      = pending_reg;
                    pending_next = '0;
                end else if (s_address == OFF_CONTROL) begin
                    rd_next = {{(DATA_W-DISABLE_BIT-1){1'b0}}, disable_reg,
                               {DISABLE_BIT{1'b0}}};
                end else if (s_address == OFF_TARGET) begin
                    rd_next = target_reg;
                end else if (!is_dummy) begin
                    status_next = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (s_address == OFF_REQUEST) begin
                    // read only: drop the word
                end else if (s_address == OFF_MASK) begin
                    mask_next = s_write_data;
                end else if (s_address == OFF_PENDING) begin
                    pending_next = '0;
                end else if (s_address == OFF_CONTROL) begin
                    disable_next = s_write_data[DISABLE_BIT];
                end else if (s_address == OFF_TARGET) begin
                    target_next = s_write_data;
                end else if (s_address == OFF_POWER) begin
                    poff_next = (s_write_data == POWER_OFF_VAL);
                end else if (!is_dummy) begin
                    status_next = 1'b1;
                end
            end
            CMD_LINE: begin
                if (s_irq_level) begin
                    pending_next = pending_reg | line_bit;
                    if ((line_bit & mask_reg) != '0) begin
                        request_next = request_reg | line_bit;
                        if (!disable_reg) begin
                            nvalid_next = 1'b1;
                            naddr_next  = {target_reg[DATA_W-1:LINE_W], {LINE_W{1'b0}}};
                            nval_next   = target_reg[LINE_W-1:0];
                        end
                    end
                end else begin
                    pending_next = pending_reg & ~line_bit;
                end
            end
            default: begin
                // unused command: no change, zero result
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lan_reg     <= LAN_RESET;
            printer_reg <= PRINTER_RESET;
            serial_reg  <= SERIAL_RESET;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LAN:     lan_reg     <= cfg_wdata;
                CFG_PRINTER: printer_reg <= cfg_wdata;
                CFG_SERIAL:  serial_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_reg   <= '0;
            mask_reg      <= '0;
            pending_reg   <= '0;
            disable_reg   <= 1'b0;
            target_reg    <= TARGET_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                request_reg <= request_next;
                mask_reg    <= mask_next;
                pending_reg <= pending_next;
                disable_reg <= disable_next;
                target_reg  <= target_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg     <= rd_next;
            status_reg <= status_next;
            nvalid_reg <= nvalid_next;
            naddr_reg  <= naddr_next;
            nval_reg   <= nval_next;
            poff_reg   <= poff_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_data      = rd_reg;
    assign m_access_status  = status_reg;
    assign m_notify_valid   = nvalid_reg;
    assign m_notify_address = naddr_reg;
    assign m_notify_value   = nval_reg;
    assign m_power_off      = poff_reg;

endmodule

FILE: hw/rtl/icr_checker.sv
// Port-level checker of the interrupt controller register core, with its
// bind. Depends on icr_pkg and interrupt_controller_registers_core_defines.svh.
`include "interrupt_controller_registers_core_defines.svh"

module icr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [icr_pkg::DATA_W-1:0] m_read_data,
    input logic                       m_access_status,
    input logic                       m_notify_valid,
    input logic [icr_pkg::DATA_W-1:0] m_notify_address,
    input logic [icr_pkg::LINE_W-1:0] m_notify_value,
    input logic                       m_power_off
);
    import icr_pkg::*;

    // an empty result register must take a word
    `ICR_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    // a notify comes only from a line event: no read data, no reject, no power-off
    `ICR_ASSERT_NOW(a_notify_clean, aclk, aresetn, m_valid && m_notify_valid,
                    (m_read_data == '0) && !m_access_status && !m_power_off)
    // a rejected access returns nothing else
    `ICR_ASSERT_NOW(a_reject_clean, aclk, aresetn, m_valid && m_access_status,
                    (m_read_data == '0) && !m_notify_valid && !m_power_off)
    // a stalled result holds
    `ICR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_read_data) && $stable(m_notify_address)
                     && $stable(m_notify_value))

endmodule

bind interrupt_controller_registers_core icr_checker u_icr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_read_data      (m_read_data),
    .m_access_status  (m_access_status),
    .m_notify_valid   (m_notify_valid),
    .m_notify_address (m_notify_address),
    .m_notify_value   (m_notify_value),
    .m_power_off      (m_power_off)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for interrupt_controller_registers_core: directed and random
// register accesses and line events, predicted and checked in a scoreboard class.
// Depends on icr_pkg and the core RTL.
module tb_top;
    import icr_pkg::*;

    localparam logic [1:0]           CMD_NONE     = 2'd3;  // ignored by the core
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;  // accepted, no register
    localparam logic [DATA_W-1:0]    NOTIFY_ALIGN = 32'hFFFF_FFE0;
    localparam int                   PHASE_WORDS  = 250;
    localparam int                   NUM_PHASES   = 6;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [LINE_W-1:0] irq_line;
        logic              irq_level;
    } bus_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_status;
        logic              notify_valid;
        logic [DATA_W-1:0] notify_address;
        logic [LINE_W-1:0] notify_value;
        logic              power_off;
    } result_word_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_STALLS} rx_mode_t;

    class icr_scoreboard;
        logic [DATA_W-1:0] req_bits, mask_bits, pend_bits, target_addr;
        logic              notify_off;
        logic [ADDR_W-1:0] lan_off, prn_off, ser_off;
        result_word_t      awaited[$];
        int                fail_count;

        function new();
            req_bits    = '0;
            mask_bits   = '0;
            pend_bits   = '0;
            notify_off  = 1'b0;
            target_addr = TARGET_RESET;
            lan_off     = LAN_RESET;
            prn_off     = PRINTER_RESET;
            ser_off     = SERIAL_RESET;
            fail_count  = 0;
        endfunction

        function void flag(string msg);
            if (fail_count < 10) $display("ERROR @%0t: %s", $time, msg);
            fail_count++;
        endfunction

        function void set_slot(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                CFG_LAN:     lan_off = value;
                CFG_PRINTER: prn_off = value;
                CFG_SERIAL:  ser_off = value;
                default: ;
            endcase
        endfunction

        // Update the register copy for one accepted word and queue its result.
        function void note_word(bus_word_t w);
            result_word_t      r;
            logic [DATA_W-1:0] line_bit;
            logic              dummy;
            r        = '0;
            line_bit = 32'd1 << w.irq_line;
            dummy    = (w.address == lan_off) || (w.address == prn_off) ||
                       (w.address == ser_off) || (w.address == OFF_POWER) ||
                       (w.address == OFF_VERSION) || (w.address == OFF_IORESET);
            case (w.cmd)
                CMD_READ: begin
                    // fixed registers win over a slot at the same offset
                    case (w.address)
                        OFF_REQUEST: r.read_data = req_bits;
                        OFF_MASK:    r.read_data = mask_bits;
                        OFF_PENDING: begin
                            r.read_data = pend_bits;
                            pend_bits   = '0;
                        end
                        OFF_CONTROL: r.read_data = notify_off ? (32'd1 << DISABLE_BIT) : '0;
                        OFF_TARGET:  r.read_data = target_addr;
                        default:     r.access_status = !dummy;
                    endcase
                end
                CMD_WRITE: begin
                    case (w.address)
                        OFF_REQUEST: ;
                        OFF_MASK:    mask_bits = w.write_data;
                        OFF_PENDING: pend_bits = '0;
                        OFF_CONTROL: notify_off = w.write_data[DISABLE_BIT];
                        OFF_TARGET:  target_addr = w.write_data;
                        OFF_POWER:   r.power_off = (w.write_data == POWER_OFF_VAL);
                        default:     r.access_status = !dummy;
                    endcase
                end
                CMD_LINE: begin
                    if (w.irq_level) begin
                        pend_bits = pend_bits | line_bit;
                        if ((line_bit & mask_bits) != '0) begin
                            req_bits = req_bits | line_bit;
                            if (!notify_off) begin
                                r.notify_valid   = 1'b1;
                                r.notify_address = target_addr & NOTIFY_ALIGN;
                                r.notify_value   = target_addr[LINE_W-1:0];
                            end
                        end
                    end else begin
                        pend_bits = pend_bits & ~line_bit;
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_word(result_word_t got);
            result_word_t exp;
            if (awaited.size() == 0) begin
                flag($sformatf("result word with nothing expected: rd=%h st=%b nv=%b",
                               got.read_data, got.access_status, got.notify_valid));
                return;
            end
            exp = awaited.pop_front();
            if (got !== exp)
                flag($sformatf({"result mismatch: exp rd=%h st=%b nv=%b na=%h nd=%h po=%b",
                                " | got rd=%h st=%b nv=%b na=%h nd=%h po=%b"},
                               exp.read_data, exp.access_status, exp.notify_valid,
                               exp.notify_address, exp.notify_value, exp.power_off,
                               got.read_data, got.access_status, got.notify_valid,
                               got.notify_address, got.notify_value, got.power_off));
        endfunction
    endclass

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [ADDR_W-1:0]    cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd        = '0;
    logic [ADDR_W-1:0]    s_address    = '0;
    logic [DATA_W-1:0]    s_write_data = '0;
    logic [LINE_W-1:0]    s_irq_line   = '0;
    logic                 s_irq_level  = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [DATA_W-1:0]    m_read_data;
    logic                 m_access_status;
    logic                 m_notify_valid;
    logic [DATA_W-1:0]    m_notify_address;
    logic [LINE_W-1:0]    m_notify_value;
    logic                 m_power_off;

    icr_scoreboard sb = new();

    int       burst_left = 0;
    int       rx_cycle   = 0;
    int       stall_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;

    interrupt_controller_registers_core DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bus_word_t bus_word(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] data,
                                           logic [LINE_W-1:0] line, logic level);
        bus_word_t w;
        w.cmd        = cmd;
        w.address    = addr;
        w.write_data = data;
        w.irq_line   = line;
        w.irq_level  = level;
        return w;
    endfunction

    function automatic bus_word_t random_word();
        bus_word_t   w;
        int          r;
        logic [31:0] rnd;
        r = $urandom_range(0, 99);
        if (r < 38)      w.cmd = CMD_LINE;
        else if (r < 68) w.cmd = CMD_READ;
        else if (r < 96) w.cmd = CMD_WRITE;
        else             w.cmd = CMD_NONE;
        w.write_data = $urandom;
        rnd          = $urandom;
        w.irq_line   = rnd[LINE_W-1:0];
        w.irq_level  = ($urandom_range(0, 99) < 65);
        rnd          = $urandom;
        r            = $urandom_range(0, 99);
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0:       w.address = OFF_REQUEST;
                1:       w.address = OFF_MASK;
                2:       w.address = OFF_PENDING;
                3:       w.address = OFF_CONTROL;
                default: w.address = OFF_TARGET;
            endcase
        end else if (r < 70) begin
            case ($urandom_range(0, 2))
                0:       w.address = sb.lan_off;
                1:       w.address = sb.prn_off;
                default: w.address = sb.ser_off;
            endcase
        end else if (r < 82) begin
            case ($urandom_range(0, 2))
                0:       w.address = OFF_POWER;
                1:       w.address = OFF_VERSION;
                default: w.address = OFF_IORESET;
            endcase
        end else if (r < 88) begin
            // low window: fixed registers and the holes between them
            w.address = {15'd0, rnd[4:0]};
        end else begin
            w.address = rnd[ADDR_W-1:0];
        end
        if (w.cmd == CMD_WRITE) begin
            r = $urandom_range(0, 9);
            if (w.address == OFF_POWER && r < 5)   w.write_data = POWER_OFF_VAL;
            else if (w.address == OFF_MASK && r == 0) w.write_data = '0;
            else if (w.address == OFF_MASK && r == 1) w.write_data = '1;
        end
        return w;
    endfunction

    // Hold the word until taken, then either keep the burst going or drop valid.
    task automatic send_word(bus_word_t w);
        int gap;
        s_valid      <= 1'b1;
        s_cmd        <= w.cmd;
        s_address    <= w.address;
        s_write_data <= w.write_data;
        s_irq_line   <= w.irq_line;
        s_irq_level  <= w.irq_level;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        int n;
        s_valid <= 1'b0;
        for (n = 0; n < 1000 && sb.awaited.size() != 0; n++) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_slot(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_slot(idx, value);
    endtask

    task automatic set_slots(logic [ADDR_W-1:0] lan, logic [ADDR_W-1:0] prn,
                             logic [ADDR_W-1:0] ser);
        logic [31:0] rnd;
        rnd = $urandom;
        write_slot(CFG_LAN, lan);
        write_slot(CFG_PRINTER, prn);
        write_slot(CFG_SERIAL, ser);
        write_slot(CFG_UNUSED, rnd[ADDR_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: check on each taken word, then pick the next ready level.
    always @(posedge aclk) begin : rx_side
        result_word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.read_data      = m_read_data;
            got.access_status  = m_access_status;
            got.notify_valid   = m_notify_valid;
            got.notify_address = m_notify_address;
            got.notify_value   = m_notify_value;
            got.power_off      = m_power_off;
            sb.check_word(got);
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  m_ready <= 1'b1;
            RX_COIN:  m_ready <= ($urandom_range(0, 1) == 1);
            RX_THIRD: m_ready <= (rx_cycle % 3 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    initial begin
        int phase;
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass at reset slot offsets
        send_word(bus_word(CMD_READ,  OFF_REQUEST, '1, '1, 1'b1));
        send_word(bus_word(CMD_READ,  OFF_CONTROL, '0, '0, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_TARGET,  '0, '0, 1'b0));
        send_word(bus_word(CMD_LINE,  20'hFFFFF,   '1, 5'd7, 1'b1));   // masked line
        send_word(bus_word(CMD_WRITE, OFF_MASK,    '1, '0, 1'b0));
        send_word(bus_word(CMD_LINE,  '0,          '0, 5'd31, 1'b1));
        send_word(bus_word(CMD_LINE,  '0,          '0, 5'd0, 1'b1));
        send_word(bus_word(CMD_LINE,  '0,          '0, 5'd31, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_PENDING, '0, '0, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_PENDING, '0, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_CONTROL, '1, '0, 1'b0));
        send_word(bus_word(CMD_LINE,  '0,          '0, 5'd3, 1'b1));   // notify held off
        send_word(bus_word(CMD_READ,  OFF_CONTROL, '0, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_CONTROL, 32'hFFFF_FF7F, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_TARGET,  32'h1234_5678, '0, 1'b0));
        send_word(bus_word(CMD_LINE,  '0,          '0, 5'd12, 1'b1));
        send_word(bus_word(CMD_WRITE, OFF_PENDING, 32'h0000_0001, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_REQUEST, '0, '0, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_REQUEST, '0, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_POWER,   POWER_OFF_VAL, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_POWER,   32'h8000_0002, '0, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_POWER,   '0, '0, 1'b0));
        send_word(bus_word(CMD_READ,  OFF_VERSION, '0, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, OFF_IORESET, '1, '0, 1'b0));
        send_word(bus_word(CMD_READ,  LAN_RESET,   '0, '0, 1'b0));
        send_word(bus_word(CMD_WRITE, SERIAL_RESET, '1, '0, 1'b0));
        send_word(bus_word(CMD_READ,  20'hFFFFF,   '0, '0, 1'b0));    // unknown offset
        send_word(bus_word(CMD_WRITE, 20'h00001,   '1, '0, 1'b0));
        send_word(bus_word(CMD_NONE,  '1,          '1, '1, 1'b1));
        send_word(bus_word(CMD_WRITE, OFF_MASK,    '0, '0, 1'b0));

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: set_slots('0, '0, '0);                       // all on the request offset
                1: set_slots('1, '1, '1);
                2: set_slots(OFF_POWER, OFF_PENDING, 20'h00014);
                3, 4: set_slots(ADDR_W'($urandom_range(0, 20'hFFFFF)),
                                ADDR_W'($urandom_range(0, 20'hFFFFF)),
                                ADDR_W'($urandom_range(0, 20'hFFFFF)));
                default: set_slots(LAN_RESET, PRINTER_RESET, SERIAL_RESET);
            endcase
            for (k = 0; k < PHASE_WORDS; k++) send_word(random_word());
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.awaited.size() != 0)
            sb.flag($sformatf("%0d result words never arrived", sb.awaited.size()));
        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/icr_pkg.sv
hw/rtl/interrupt_controller_registers_core.sv
hw/rtl/icr_checker.sv
verif/tb_top.sv
